// ===== rtl/clwfe_pkg.sv =====
package clwfe_pkg;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_CHAR   = 2'd1,
    ACT_NUM    = 2'd2,
    ACT_CURSOR = 2'd3
  } action_e;

  localparam logic [7:0]  LINE1_BASE  = 8'h80;
  localparam logic [7:0]  LINE2_BASE  = 8'hC0;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  // floor(v / 10) = (v * 52429) >> 19, exact for every 16-bit v
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    action_e     action;
    logic [7:0]  byte_value;
    logic [15:0] number;
    logic [5:0]  column;
    logic        on_first_line;
  } in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic       is_num;
    logic       is_data;
    logic [7:0] bus_byte;
  } wr_t;

endpackage

// ===== rtl/char_lcd_write_front_end.sv =====
// channel | direction | payload                 | handshake
// in      | input     | in_i  (clwfe_pkg::in_t)  | in_valid_i / in_ready_o
// out     | output    | out_o (clwfe_pkg::out_t) | out_valid_o / out_ready_i
//
// an item passes the pipeline stages and the digit serializer before it reaches the output register
// single writes stream at one item per cycle while the output and serializer do not stall
// a number write holds the digit serializer until each of its printed digits is emitted
// one reciprocal multiply in each stage after the first extracts one decimal digit
// rst_ni clears all valid bits; payload registers are not reset
// a stall at the output backs up stage by stage, bubbles are squeezed out
module char_lcd_write_front_end #(
  parameter int MAX_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  clwfe_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output clwfe_pkg::out_t  out_o
);
  import clwfe_pkg::*;

  localparam int NS = MAX_DIGITS + 1;
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LIMIT = 10 ** MAX_DIGITS;

  typedef logic [MAX_DIGITS-1:0][3:0] dig_t;

  // pipeline stages
  logic [NS-1:0] vld_q;
  wr_t           wr_q  [NS];
  logic [15:0]   val_q [NS-1];
  dig_t          dig_q [NS];
  logic [NS:0]   rdy;

  // input decode
  wr_t  in_wr;
  logic drop;

  always_comb begin
    in_wr = '0;
    unique case (in_i.action)
      ACT_CMD: begin
        in_wr.bus_byte = in_i.byte_value;
      end
      ACT_CHAR: begin
        in_wr.is_data  = 1'b1;
        in_wr.bus_byte = in_i.byte_value;
      end
      ACT_NUM: begin
        in_wr.is_num  = 1'b1;
        in_wr.is_data = 1'b1;
      end
      ACT_CURSOR: begin
        in_wr.bus_byte = (in_i.on_first_line ? LINE1_BASE : LINE2_BASE)
                         + {2'b00, in_i.column};
      end
      default: in_wr = '0;
    endcase
  end

  assign drop = (in_i.action == ACT_NUM) && (32'(in_i.number) >= LIMIT);

  // digit extraction per stage
  logic [15:0] quo  [1:NS-1];
  logic [3:0]  dgt  [1:NS-1];
  logic [31:0] prod [1:NS-1];

  always_comb begin
    for (int k = 1; k < NS; k++) begin
      prod[k] = val_q[k-1] * DIV10_MUL;
      quo[k]  = 16'(prod[k] >> DIV10_SHIFT);
      dgt[k]  = 4'(val_q[k-1] - {quo[k][12:0], 3'b000} - {quo[k][14:0], 1'b0});
    end
  end

  // serializer and output register
  logic           s_vld_q;
  wr_t            s_wr_q;
  dig_t           s_dig_q;
  logic [IW-1:0]  s_idx_q;
  logic           out_valid_q;
  out_t           out_q;
  logic           o_free;
  logic           s_emit;
  logic           s_final;
  logic           s_take;
  out_t           s_word;
  logic [IW-1:0]  top;

  assign o_free  = !out_valid_q || out_ready_i;
  assign s_emit  = s_vld_q && o_free;
  assign s_final = !s_wr_q.is_num || (s_idx_q == '0);
  assign s_take  = !s_vld_q || (s_emit && s_final);

  always_comb begin
    rdy[NS] = s_take;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_comb begin
    top = '0;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (dig_q[NS-1][i] != 4'd0) begin
        top = IW'(i);
      end
    end
  end

  always_comb begin
    s_word.is_data  = s_wr_q.is_data;
    s_word.bus_byte = s_wr_q.is_num ? (ASCII_ZERO + {4'd0, s_dig_q[s_idx_q]})
                                    : s_wr_q.bus_byte;
    s_word.last     = s_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      s_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i && !drop;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (s_take) begin
        s_vld_q <= vld_q[NS-1];
      end
      if (s_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      wr_q[0]  <= in_wr;
      val_q[0] <= in_i.number;
      dig_q[0] <= '0;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        wr_q[k] <= wr_q[k-1];
        if (k < NS - 1) begin
          val_q[k] <= quo[k];
        end
        for (int j = 0; j < MAX_DIGITS; j++) begin
          dig_q[k][j] <= (j == k - 1) ? dgt[k] : dig_q[k-1][j];
        end
      end
    end
    if (s_take) begin
      s_wr_q  <= wr_q[NS-1];
      s_dig_q <= dig_q[NS-1];
      s_idx_q <= wr_q[NS-1].is_num ? top : '0;
    end else if (s_emit) begin
      s_idx_q <= s_idx_q - 1'b1;
    end
    if (s_emit) begin
      out_q <= s_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  // a number that does not fit never enters the pipeline
  a_drop_large: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && drop |=> !vld_q[0])
    else $error("oversized number entered pipeline");

  // a write that is not last leaves its remaining digits in the serializer
  a_more_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> s_vld_q && s_wr_q.is_num)
    else $error("non-last write without pending digits");

  // command writes are always single
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_data |-> out_q.last)
    else $error("command write not marked last");

  // the leading printed digit is never a zero unless it is the only one
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_vld_q) && s_wr_q.is_num |-> s_dig_q[s_idx_q] != 4'd0 || s_idx_q == '0)
    else $error("leading zero digit");

  // single writes start with a zero digit index
  a_single_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q && !s_wr_q.is_num |-> s_idx_q == '0)
    else $error("single write with digit index");
`endif

endmodule
